@@ hw/rtl/nzf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nzf_pkg
// Shared types and constants of the nonzero index finder: transfer payloads,
// the ring entry held by each cell and the register indexes.
// ----------------------------------------------------------------------------
package nzf_pkg;

   localparam int DATA_W       = 32;
   localparam int ROW_W        = 16;
   localparam int COUNT_W      = 32;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int KEEP_LIMIT_W = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_ROWS     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEEP_LIMIT   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAKE_LAST    = 2'd3;

   typedef struct packed {
      logic signed [DATA_W-1:0] elem_real;
      logic signed [DATA_W-1:0] elem_imag;
      logic                     end_of_array;
   } req_payload_type;

   typedef struct packed {
      logic                     has_entry;
      logic [COUNT_W-1:0]       linear_position;
      logic [ROW_W-1:0]         row_position;
      logic [COUNT_W-1:0]       col_position;
      logic signed [DATA_W-1:0] match_real;
      logic signed [DATA_W-1:0] match_imag;
      logic                     last_result;
   } rsp_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0]       linear;
      logic [ROW_W-1:0]         row;
      logic [COUNT_W-1:0]       col;
      logic signed [DATA_W-1:0] real_part;
      logic signed [DATA_W-1:0] imag_part;
   } ring_entry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_status_type;

endpackage

@@ hw/rtl/nzf_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nzf_cell
// One ring slot: captures a match when addressed, otherwise takes its
// neighbor's entry while the ring rotates.
// ----------------------------------------------------------------------------
module nzf_cell (
   input  logic                    clock,
   input  logic                    wr_en,
   input  nzf_pkg::ring_entry_type wr_data,
   input  logic                    shift_en,
   input  nzf_pkg::ring_entry_type shift_data,
   output nzf_pkg::ring_entry_type entry
);
   import nzf_pkg::*;

   ring_entry_type entry_ff;
   ring_entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (wr_en) begin
         entry_in = wr_data;
      end else if (shift_en) begin
         entry_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ hw/rtl/nzf_cell_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nzf_cell_chain
// Row of ring cells. A match is written to the addressed cell; during the
// drain the first k cells rotate by one toward cell 0 every enabled cycle.
// ----------------------------------------------------------------------------
module nzf_cell_chain #(
   parameter int MAX_KEEP = 32,
   parameter int PW       = 5,
   parameter int KW       = 6
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [PW-1:0]           wr_addr,
   input  nzf_pkg::ring_entry_type wr_data,
   input  logic                    rot_en,
   input  logic [KW-1:0]           rot_k,
   output nzf_pkg::ring_entry_type head
);
   import nzf_pkg::*;

   ring_entry_type cell_q [MAX_KEEP];

   for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
      localparam logic [KW-1:0] CELL_IDX  = KW'(i);
      localparam logic [PW-1:0] CELL_ADDR = PW'(i);
      ring_entry_type neighbor;

      if (i == MAX_KEEP - 1) begin : g_tail
         assign neighbor = cell_q[0];
      end else begin : g_body
         localparam logic [KW-1:0] NEXT_IDX = KW'(i + 1);
         assign neighbor = (NEXT_IDX < rot_k) ? cell_q[i + 1] : cell_q[0];
      end

      nzf_cell u_cell (
         .clock      (clock),
         .wr_en      (wr_en && (wr_addr == CELL_ADDR)),
         .wr_data    (wr_data),
         .shift_en   (rot_en && (CELL_IDX < rot_k)),
         .shift_data (neighbor),
         .entry      (cell_q[i])
      );
   end

   assign head = cell_q[0];

endmodule

@@ hw/rtl/nzf_ptr_mod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nzf_ptr_mod
// Bit-serial remainder of the ring write pointer by a new limit, one
// dividend bit per cycle.
// ----------------------------------------------------------------------------
module nzf_ptr_mod #(
   parameter int PW = 5,
   parameter int KW = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [PW-1:0]           dividend,
   input  logic [KW-1:0]           divisor,
   output nzf_pkg::mod_status_type status,
   output logic [PW-1:0]           remainder
);
   import nzf_pkg::*;

   localparam int CW = $clog2(PW + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] dvd_ff, dvd_in;
   logic [KW-1:0] div_ff, div_in;
   logic [KW-1:0] rem_ff, rem_in;
   logic [KW:0]   trial;
   logic [KW:0]   step_rem;

   always_comb begin
      trial    = {rem_ff, dvd_ff[PW-1]};
      step_rem = (trial >= {1'b0, div_ff}) ? (trial - {1'b0, div_ff}) : trial;
      cnt_in   = cnt_ff;
      dvd_in   = dvd_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      if (start) begin
         cnt_in = CW'(PW);
         dvd_in = dividend;
         div_in = divisor;
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CW'(1);
         dvd_in = dvd_ff << 1;
         rem_in = step_rem[KW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign status.busy = (cnt_ff != '0);
   assign status.done = (cnt_ff == CW'(1));
   assign remainder   = PW'(step_rem[KW-1:0]);

endmodule

@@ hw/rtl/nonzero_index_finder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonzero_index_finder
// Stream compaction of a column-major matrix: reports the position and value
// of nonzero elements (real or imaginary part): all, or the first or last k.
// ----------------------------------------------------------------------------
// Elements enter on the req_ channel, one transfer per element, the final one
// flagged by end_of_array. Results leave on the rsp_ channel from an output
// register; a direct result or marker is registered in the cycle after its
// element. One element per cycle is taken while the result side keeps up and
// no drain or pointer reduction runs. Registers are to be written on the csr_
// port only while no element is in flight; the block does not enforce this.
// A write to keep_limit reduces the ring write pointer bit-serially, holding
// req_stall high meanwhile. In keep-last mode the end of the array starts a
// drain through the cell ring: the ring first rotates until its oldest entry
// sits in cell 0, then sends one result per cycle while the result side keeps
// up, oldest first, and finally turns on until every cell is back in its own
// slot. No element is taken during the drain. Every array closes with a
// transfer flagged last_result, an empty marker when nothing is left to send.
// When rsp_stall is high the result holds and req_stall follows it.
// Reset clears the counters and the ring pointer and fill and restores the
// register defaults; the ring cells themselves are not cleared.
// ----------------------------------------------------------------------------
module nonzero_index_finder #(
   parameter int MAX_KEEP = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  nzf_pkg::req_payload_type            req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output nzf_pkg::rsp_payload_type            rsp_data,
   input  logic                                csr_we,
   input  logic [nzf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [nzf_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import nzf_pkg::*;

   localparam int PW  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int KW  = $clog2(MAX_KEEP + 1);
   localparam int KLW = KEEP_LIMIT_W + 1;
   localparam logic [KW-1:0]  KMAX      = KW'(MAX_KEEP);
   localparam logic [KLW-1:0] KMAX_WIDE = KLW'(MAX_KEEP);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_ALIGN   = 4'b0010,
      ST_EMIT    = 4'b0100,
      ST_RESTORE = 4'b1000
   } drain_state_type;

   function automatic logic [KW-1:0] sat_limit(input logic [KEEP_LIMIT_W-1:0] v);
      logic [KW-1:0] r;
      r = ({1'b0, v} > KMAX_WIDE) ? KMAX : KW'(v);
      return r;
   endfunction

   // configuration
   logic [ROW_W-1:0]        num_rows_ff, num_rows_in;
   logic                    limit_enable_ff, limit_enable_in;
   logic [KEEP_LIMIT_W-1:0] keep_limit_ff, keep_limit_in;
   logic                    take_last_ff, take_last_in;

   // array state
   logic [COUNT_W-1:0] elem_ff, elem_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COUNT_W-1:0] col_ff, col_in;
   logic [KW-1:0]      mc_ff, mc_in;
   logic [PW-1:0]      w_ff, w_in;
   logic [PW-1:0]      w_mod_ff, w_mod_in;
   logic [KW-1:0]      f_ff, f_in;

   // drain control
   drain_state_type    state_ff, state_in;
   logic [KW-1:0]      rot_cnt_ff, rot_cnt_in;
   logic [KW-1:0]      emit_cnt_ff, emit_cnt_in;
   logic [KW-1:0]      back_cnt_ff, back_cnt_in;
   logic [KW-1:0]      drain_k_ff, drain_k_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic               req_accept;
   logic               out_free;
   logic               is_match;
   logic               eoa;
   logic               ring_mode;
   logic [KW-1:0]      eff_k;
   logic [ROW_W-1:0]   rows_eff;
   logic [COUNT_W-1:0] lin_now;
   logic [KW-1:0]      f_sat;
   logic [PW-1:0]      w_norm;
   logic [KW-1:0]      f_norm;
   logic [KW-1:0]      w_inc;
   logic [PW-1:0]      w_next;
   logic [KW-1:0]      f_next;
   logic [KW:0]        start_sum;
   logic [KW-1:0]      start_pos;
   logic               ring_event;
   logic               ring_write;
   logic               drain_start;
   logic               direct_hit;
   logic               marker;
   logic               rot_en;
   logic               mod_start;
   mod_status_type     mod_status;
   logic [PW-1:0]      mod_rem;
   ring_entry_type     wr_entry;
   ring_entry_type     head;

   assign eff_k      = sat_limit(keep_limit_ff);
   assign ring_mode  = limit_enable_ff && take_last_ff;
   assign is_match   = (req_data.elem_real != '0) || (req_data.elem_imag != '0);
   assign eoa        = req_data.end_of_array;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || mod_status.busy || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign rows_eff   = (num_rows_ff == '0) ? ROW_W'(1) : num_rows_ff;
   assign lin_now    = elem_ff + COUNT_W'(1);
   assign mod_start  = csr_we && (csr_index == CSR_KEEP_LIMIT);

   // configuration writes
   always_comb begin
      num_rows_in     = num_rows_ff;
      limit_enable_in = limit_enable_ff;
      keep_limit_in   = keep_limit_ff;
      take_last_in    = take_last_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_NUM_ROWS:     num_rows_in     = csr_wdata[ROW_W-1:0];
            CSR_LIMIT_ENABLE: limit_enable_in = csr_wdata[0];
            CSR_KEEP_LIMIT:   keep_limit_in   = csr_wdata[KEEP_LIMIT_W-1:0];
            CSR_TAKE_LAST:    take_last_in    = csr_wdata[0];
            default:          num_rows_in     = num_rows_ff;
         endcase
      end
   end

   // ring pointer and fill
   always_comb begin
      f_sat = (f_ff > eff_k) ? eff_k : f_ff;
      if (eff_k == '0) begin
         w_norm = '0;
         f_norm = '0;
      end else begin
         w_norm = w_mod_ff;
         f_norm = f_sat;
      end
      w_inc = KW'(w_norm) + KW'(1);
      if (is_match && (eff_k != '0)) begin
         w_next = (w_inc == eff_k) ? '0 : PW'(w_inc);
         f_next = (f_norm < eff_k) ? (f_norm + KW'(1)) : f_norm;
      end else begin
         w_next = w_norm;
         f_next = f_norm;
      end
      start_sum = {1'b0, KW'(w_next)} + {1'b0, eff_k} - {1'b0, f_next};
      start_pos = (start_sum >= {1'b0, eff_k}) ? KW'(start_sum - {1'b0, eff_k})
                                               : KW'(start_sum);
   end

   assign ring_event  = req_accept && ring_mode && (is_match || eoa);
   assign ring_write  = req_accept && ring_mode && is_match && (eff_k != '0);
   assign drain_start = req_accept && eoa && ring_mode && (f_next != '0);
   assign direct_hit  = !ring_mode && is_match && (!limit_enable_ff || (mc_ff < eff_k));
   assign marker      = eoa && (ring_mode ? (f_next == '0) : !direct_hit);

   assign wr_entry.linear    = lin_now;
   assign wr_entry.row       = row_ff;
   assign wr_entry.col       = col_ff;
   assign wr_entry.real_part = req_data.elem_real;
   assign wr_entry.imag_part = req_data.elem_imag;

   // array counters
   always_comb begin
      elem_in  = elem_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      mc_in    = mc_ff;
      w_in     = w_ff;
      w_mod_in = w_mod_ff;
      f_in     = f_ff;
      if (mod_status.done) begin
         w_mod_in = mod_rem;
      end
      if (req_accept) begin
         if (eoa) begin
            elem_in  = '0;
            row_in   = ROW_W'(1);
            col_in   = COUNT_W'(1);
            mc_in    = '0;
            w_in     = '0;
            w_mod_in = '0;
            f_in     = '0;
         end else begin
            elem_in = lin_now;
            if (row_ff >= rows_eff) begin
               row_in = ROW_W'(1);
               col_in = col_ff + COUNT_W'(1);
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
            if (is_match && (mc_ff != KMAX)) begin
               mc_in = mc_ff + KW'(1);
            end
            if (ring_event) begin
               w_in     = w_next;
               w_mod_in = w_next;
               f_in     = f_next;
            end
         end
      end
   end

   // drain sequencer
   always_comb begin
      state_in    = state_ff;
      rot_cnt_in  = rot_cnt_ff;
      emit_cnt_in = emit_cnt_ff;
      back_cnt_in = back_cnt_ff;
      drain_k_in  = drain_k_ff;
      rot_en      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (drain_start) begin
               drain_k_in  = eff_k;
               emit_cnt_in = f_next;
               rot_cnt_in  = start_pos;
               back_cnt_in = (w_next == '0) ? '0 : (eff_k - KW'(w_next));
               state_in    = (start_pos == '0) ? ST_EMIT : ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            rot_en     = 1'b1;
            rot_cnt_in = rot_cnt_ff - KW'(1);
            if (rot_cnt_ff == KW'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rot_en      = 1'b1;
               emit_cnt_in = emit_cnt_ff - KW'(1);
               if (emit_cnt_ff == KW'(1)) begin
                  state_in = (back_cnt_ff == '0) ? ST_IDLE : ST_RESTORE;
               end
            end
         end
         ST_RESTORE: begin
            rot_en      = 1'b1;
            back_cnt_in = back_cnt_ff - KW'(1);
            if (back_cnt_ff == KW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (req_accept && (direct_hit || marker)) begin
         rsp_valid_in = 1'b1;
         if (direct_hit) begin
            rsp_data_in.has_entry       = 1'b1;
            rsp_data_in.linear_position = lin_now;
            rsp_data_in.row_position    = row_ff;
            rsp_data_in.col_position    = col_ff;
            rsp_data_in.match_real      = req_data.elem_real;
            rsp_data_in.match_imag      = req_data.elem_imag;
            rsp_data_in.last_result     = eoa;
         end else begin
            rsp_data_in.has_entry       = 1'b0;
            rsp_data_in.linear_position = '0;
            rsp_data_in.row_position    = '0;
            rsp_data_in.col_position    = '0;
            rsp_data_in.match_real      = '0;
            rsp_data_in.match_imag      = '0;
            rsp_data_in.last_result     = 1'b1;
         end
      end else if ((state_ff == ST_EMIT) && out_free) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.has_entry       = 1'b1;
         rsp_data_in.linear_position = head.linear;
         rsp_data_in.row_position    = head.row;
         rsp_data_in.col_position    = head.col;
         rsp_data_in.match_real      = head.real_part;
         rsp_data_in.match_imag      = head.imag_part;
         rsp_data_in.last_result     = (emit_cnt_ff == KW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff     <= ROW_W'(1);
         limit_enable_ff <= 1'b0;
         keep_limit_ff   <= '0;
         take_last_ff    <= 1'b0;
         elem_ff         <= '0;
         row_ff          <= ROW_W'(1);
         col_ff          <= COUNT_W'(1);
         mc_ff           <= '0;
         w_ff            <= '0;
         w_mod_ff        <= '0;
         f_ff            <= '0;
         state_ff        <= ST_IDLE;
         rot_cnt_ff      <= '0;
         emit_cnt_ff     <= '0;
         back_cnt_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         num_rows_ff     <= num_rows_in;
         limit_enable_ff <= limit_enable_in;
         keep_limit_ff   <= keep_limit_in;
         take_last_ff    <= take_last_in;
         elem_ff         <= elem_in;
         row_ff          <= row_in;
         col_ff          <= col_in;
         mc_ff           <= mc_in;
         w_ff            <= w_in;
         w_mod_ff        <= w_mod_in;
         f_ff            <= f_in;
         state_ff        <= state_in;
         rot_cnt_ff      <= rot_cnt_in;
         emit_cnt_ff     <= emit_cnt_in;
         back_cnt_ff     <= back_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      drain_k_ff  <= drain_k_in;
      rsp_data_ff <= rsp_data_in;
   end

   nzf_ptr_mod #(
      .PW (PW),
      .KW (KW)
   ) u_ptr_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (w_ff),
      .divisor   (sat_limit(csr_wdata[KEEP_LIMIT_W-1:0])),
      .status    (mod_status),
      .remainder (mod_rem)
   );

   nzf_cell_chain #(
      .MAX_KEEP (MAX_KEEP),
      .PW       (PW),
      .KW       (KW)
   ) u_chain (
      .clock   (clock),
      .wr_en   (ring_write),
      .wr_addr (w_norm),
      .wr_data (wr_entry),
      .rot_en  (rot_en),
      .rot_k   (drain_k_ff),
      .head    (head)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      f_ff <= KMAX)
      else $error("ring fill above capacity");

   a_drain_closes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && emit_cnt_ff == KW'(1))
      |=> ((state_ff == ST_IDLE || state_ff == ST_RESTORE) && rsp_valid_ff
           && rsp_data_ff.last_result))
      else $error("drain did not close with a last transfer");

   a_ptr_reduced: assert property (@(posedge clock) disable iff (reset)
      (!mod_status.busy && eff_k != '0) |-> (KW'(w_mod_ff) < eff_k))
      else $error("reduced write pointer not below limit");

endmodule
